>>> rtl/svafm_pkg.sv
`default_nettype none

package svafm_pkg;

  localparam int PHASE_BITS      = 32;
  localparam int TABLE_ADDR_BITS = 10;
  localparam int ROM_DEPTH       = 1 << TABLE_ADDR_BITS;
  localparam int ROM_W           = 15;

  // Configuration register indexes.
  localparam logic [2:0] REG_MODE         = 3'd0;
  localparam logic [2:0] REG_AMPLITUDE    = 3'd1;
  localparam logic [2:0] REG_CARRIER_STEP = 3'd2;
  localparam logic [2:0] REG_MOD_STEP     = 3'd3;
  localparam logic [2:0] REG_AM_DEPTH     = 3'd4;
  localparam logic [2:0] REG_FM_DEVIATION = 3'd5;

  // Voice modes.
  localparam logic [1:0] MODE_TONE = 2'd0;
  localparam logic [1:0] MODE_MIX  = 2'd1;
  localparam logic [1:0] MODE_AM   = 2'd2;
  localparam logic [1:0] MODE_FM   = 2'd3;

  localparam logic signed [15:0] AMPLITUDE_RST = 16'sd16384;

  typedef logic [ROM_W-1:0] rom_t [ROM_DEPTH];

  // Quarter-wave sine table, evaluated at elaboration with a Q30 odd polynomial
  // taken at the center of each table cell.
  function automatic rom_t build_rom();
    rom_t   tbl;
    longint x;
    longint x2;
    longint p;
    longint r;
    for (int k = 0; k < ROM_DEPTH; k++) begin
      x  = longint'((2 * k) + 1) <<< (29 - TABLE_ADDR_BITS);
      x2 = (x * x) >>> 30;
      p  = 64'sd61;
      p  = -64'sd3864      + ((p * x2) >>> 30);
      p  = 64'sd172272     + ((p * x2) >>> 30);
      p  = -64'sd5026995   + ((p * x2) >>> 30);
      p  = 64'sd85569306   + ((p * x2) >>> 30);
      p  = -64'sd693598668 + ((p * x2) >>> 30);
      p  = 64'sd1686629713 + ((p * x2) >>> 30);
      r  = (((p * x) >>> 30) + 64'sd16384) >>> 15;
      if (r < 0) r = 0;
      if (r > 32767) r = 32767;
      tbl[k] = r[ROM_W-1:0];
    end
    return tbl;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

endpackage

`default_nettype wire

>>> rtl/sine_voice_am_fm_synth.sv
`default_nettype none

// Sine voice with AM and FM: each input beat (one sample tick) yields one Q1.15
// output beat. Carrier and modulator phases are PHASE_BITS-wide accumulators;
// sines come from a registered quarter-wave ROM. A short microprogram drives
// one ROM port and one shared 32x16 signed multiplier. The result beat enters
// the output register at the microprogram's final step, once that register is
// free; how long a beat takes is set by the number of multiplier passes its mode
// needs. The next beat is taken once the current one has been handed to
// the output register, which holds a finished sample while the downstream
// side stalls. Configuration must be written only while the block is idle;
// the block itself does not enforce this.
module sine_voice_am_fm_synth
  import svafm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [15:0] in_sample
  input  wire logic        in_tuser,   // [0] restart
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [15:0] sample
  output logic             out_tuser,  // [0] clipped
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata
);

  localparam int UPC_W  = 4;
  localparam int PROD_W = 48;
  localparam int RES_W  = 20;
  localparam int ACC_W  = 18;
  localparam int IDX_W  = TABLE_ADDR_BITS + 2;

  typedef enum logic [1:0] {MA_AMP, MA_DEPTH, MA_FMDEV, MA_ACC} mul_a_t;
  typedef enum logic [1:0] {WB_NONE, WB_RES, WB_STEP, WB_ACC} wb_t;
  typedef enum logic [1:0] {J_NONE, J_ALWAYS, J_IF_AM, J_IF_NOT_FM} jmp_t;

  typedef struct packed {
    logic             rom_mod;  // ROM address from modulator phase, else carrier
    logic             ld_sm;
    logic             ld_sc;
    logic             mul_en;
    mul_a_t           mul_a;
    logic             mul_b_sm; // multiplier B is sin(mod), else sin(carrier)
    wb_t              wb;
    jmp_t             jmp;
    logic [UPC_W-1:0] target;
    logic             fin;
  } ucode_t;

  localparam int NSTEPS = 12;
  localparam logic [UPC_W-1:0] UPC_AM  = UPC_W'(7);
  localparam logic [UPC_W-1:0] UPC_FIN = UPC_W'(11);

  typedef ucode_t prog_t [NSTEPS];

  localparam prog_t PROG = '{
    // 0: look up the modulator
    '{1'b1, 1'b0, 1'b0, 1'b0, MA_AMP,   1'b0, WB_NONE, J_NONE,      '0,      1'b0},
    // 1: latch sin(mod), look up the carrier
    '{1'b0, 1'b1, 1'b0, 1'b0, MA_AMP,   1'b0, WB_NONE, J_NONE,      '0,      1'b0},
    // 2: latch sin(carrier), branch off for AM
    '{1'b0, 1'b0, 1'b1, 1'b0, MA_AMP,   1'b0, WB_NONE, J_IF_AM,     UPC_AM,  1'b0},
    // 3: amp * sin(carrier)
    '{1'b0, 1'b0, 1'b0, 1'b1, MA_AMP,   1'b0, WB_NONE, J_NONE,      '0,      1'b0},
    // 4: scale (and mix); only FM goes on
    '{1'b0, 1'b0, 1'b0, 1'b0, MA_AMP,   1'b0, WB_RES,  J_IF_NOT_FM, UPC_FIN, 1'b0},
    // 5: deviation * sin(mod)
    '{1'b0, 1'b0, 1'b0, 1'b1, MA_FMDEV, 1'b1, WB_NONE, J_NONE,      '0,      1'b0},
    // 6: modulated carrier step
    '{1'b0, 1'b0, 1'b0, 1'b0, MA_AMP,   1'b0, WB_STEP, J_ALWAYS,    UPC_FIN, 1'b0},
    // 7: depth * sin(mod)
    '{1'b0, 1'b0, 1'b0, 1'b1, MA_DEPTH, 1'b1, WB_NONE, J_NONE,      '0,      1'b0},
    // 8: envelope = amp + scaled product
    '{1'b0, 1'b0, 1'b0, 1'b0, MA_AMP,   1'b0, WB_ACC,  J_NONE,      '0,      1'b0},
    // 9: envelope * sin(carrier)
    '{1'b0, 1'b0, 1'b0, 1'b1, MA_ACC,   1'b0, WB_NONE, J_NONE,      '0,      1'b0},
    // 10: scale
    '{1'b0, 1'b0, 1'b0, 1'b0, MA_AMP,   1'b0, WB_RES,  J_NONE,      '0,      1'b0},
    // 11: saturate, emit, advance phases
    '{1'b0, 1'b0, 1'b0, 1'b0, MA_AMP,   1'b0, WB_NONE, J_NONE,      '0,      1'b1}
  };

  // Configuration registers.
  logic [1:0]         mode_r;
  logic signed [15:0] amplitude_r;
  logic [31:0]        carrier_step_r;
  logic [31:0]        mod_step_r;
  logic signed [15:0] am_depth_r;
  logic signed [31:0] fm_deviation_r;

  // Sequencer and state.
  logic                  busy_r;
  logic [UPC_W-1:0]      upc_r;
  logic [PHASE_BITS-1:0] car_phase_r;
  logic [PHASE_BITS-1:0] mod_phase_r;
  logic                  out_valid_r;

  // Datapath.
  logic signed [15:0]       in_sample_r;
  logic [ROM_W-1:0]         rom_q_r;
  logic                     rom_neg_r;
  logic signed [15:0]       sm_r;
  logic signed [15:0]       sc_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [RES_W-1:0]  res_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic [PHASE_BITS-1:0]    cstep_r;
  logic [15:0]              out_data_r;
  logic                     out_clip_r;

  ucode_t                    uc;
  logic [IDX_W-1:0]          rom_idx;
  logic [TABLE_ADDR_BITS-1:0] rom_k;
  logic signed [15:0]        sine_val;
  logic signed [31:0]        mul_a;
  logic signed [15:0]        mul_b;
  logic signed [PROD_W-15-1:0] prod_sh;
  logic signed [RES_W-1:0]   res_nxt;
  logic signed [ACC_W-1:0]   acc_nxt;
  logic [63:0]               cstep_wide;
  logic [15:0]               sat_val;
  logic                      sat_clip;
  logic                      take_in;
  logic                      emit;
  logic                      jump;

  assign uc        = PROG[upc_r];
  assign in_tready = !busy_r;
  assign take_in   = in_tvalid && in_tready;
  assign emit      = busy_r && uc.fin && (!out_valid_r || out_tready);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_clip_r;

  // Quarter-wave folding: odd quadrants mirror the index, the upper half negates.
  assign rom_idx  = uc.rom_mod ? mod_phase_r[PHASE_BITS-1 -: IDX_W]
                               : car_phase_r[PHASE_BITS-1 -: IDX_W];
  assign rom_k    = rom_idx[IDX_W-2] ? ~rom_idx[TABLE_ADDR_BITS-1:0]
                                     : rom_idx[TABLE_ADDR_BITS-1:0];
  assign sine_val = rom_neg_r ? -$signed({1'b0, rom_q_r}) : $signed({1'b0, rom_q_r});

  always_comb begin
    case (uc.mul_a)
      MA_AMP:   mul_a = 32'(amplitude_r);
      MA_DEPTH: mul_a = 32'(am_depth_r);
      MA_FMDEV: mul_a = fm_deviation_r;
      MA_ACC:   mul_a = 32'(acc_r);
      default:  mul_a = 32'(amplitude_r);
    endcase
  end

  assign mul_b   = uc.mul_b_sm ? sm_r : sc_r;
  assign prod_sh = prod_r[PROD_W-1:15];

  always_comb begin
    if (mode_r == MODE_MIX) begin
      res_nxt = (RES_W'(in_sample_r) + RES_W'(prod_sh)) >>> 1;
    end else begin
      res_nxt = RES_W'(prod_sh);
    end
  end

  assign acc_nxt    = ACC_W'(amplitude_r) + ACC_W'(prod_sh);
  assign cstep_wide = 64'(carrier_step_r) + 64'(prod_sh);

  always_comb begin
    if (res_r > RES_W'(32767)) begin
      sat_val  = 16'h7fff;
      sat_clip = 1'b1;
    end else if (res_r < -RES_W'(32768)) begin
      sat_val  = 16'h8000;
      sat_clip = 1'b1;
    end else begin
      sat_val  = res_r[15:0];
      sat_clip = 1'b0;
    end
  end

  always_comb begin
    case (uc.jmp)
      J_NONE:      jump = 1'b0;
      J_ALWAYS:    jump = 1'b1;
      J_IF_AM:     jump = (mode_r == MODE_AM);
      J_IF_NOT_FM: jump = (mode_r != MODE_FM);
      default:     jump = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= MODE_TONE;
      amplitude_r    <= AMPLITUDE_RST;
      carrier_step_r <= '0;
      mod_step_r     <= '0;
      am_depth_r     <= '0;
      fm_deviation_r <= '0;
      busy_r         <= 1'b0;
      upc_r          <= '0;
      car_phase_r    <= '0;
      mod_phase_r    <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MODE:         mode_r         <= cfg_wdata[1:0];
          REG_AMPLITUDE:    amplitude_r    <= cfg_wdata[15:0];
          REG_CARRIER_STEP: carrier_step_r <= cfg_wdata;
          REG_MOD_STEP:     mod_step_r     <= cfg_wdata;
          REG_AM_DEPTH:     am_depth_r     <= cfg_wdata[15:0];
          REG_FM_DEVIATION: fm_deviation_r <= cfg_wdata;
          default: ;
        endcase
      end

      if (out_valid_r && out_tready && !emit) begin
        out_valid_r <= 1'b0;
      end

      if (take_in) begin
        busy_r <= 1'b1;
        upc_r  <= '0;
        if (in_tuser) begin
          car_phase_r <= '0;
          mod_phase_r <= '0;
        end
      end else if (busy_r) begin
        if (uc.fin) begin
          if (emit) begin
            busy_r      <= 1'b0;
            out_valid_r <= 1'b1;
            car_phase_r <= car_phase_r + cstep_r;
            mod_phase_r <= mod_phase_r + PHASE_BITS'(mod_step_r);
          end
        end else if (jump) begin
          upc_r <= uc.target;
        end else begin
          upc_r <= upc_r + UPC_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rom_q_r   <= SINE_ROM[rom_k];
    rom_neg_r <= rom_idx[IDX_W-1];
    if (take_in) begin
      in_sample_r <= $signed(in_tdata);
      cstep_r     <= PHASE_BITS'(carrier_step_r);
    end
    if (busy_r) begin
      if (uc.ld_sm) sm_r <= sine_val;
      if (uc.ld_sc) sc_r <= sine_val;
      if (uc.mul_en) prod_r <= mul_a * mul_b;
      case (uc.wb)
        WB_NONE: ;
        WB_RES:  res_r   <= res_nxt;
        WB_STEP: cstep_r <= cstep_wide[PHASE_BITS-1:0];
        WB_ACC:  acc_r   <= acc_nxt;
        default: ;
      endcase
    end
    if (emit) begin
      out_data_r <= sat_val;
      out_clip_r <= sat_clip;
    end
  end

endmodule

`default_nettype wire

>>> verif/tb_sine_voice_am_fm_synth.sv
`timescale 1ns / 100ps

module tb_sine_voice_am_fm_synth;
  import svafm_pkg::*;

  localparam int          CYCLE_LIMIT    = 500000;
  localparam int          RANDOM_ITEMS   = 1100;
  localparam int          MAX_PRINTS     = 40;
  localparam logic [2:0]  REG_SPARE_LO   = 3'd6;
  localparam logic [2:0]  REG_SPARE_HI   = 3'd7;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] amp;
    logic [31:0] cstep;
    logic [31:0] mstep;
    logic [15:0] depth;
    logic [31:0] dev;
  } voice_cfg_t;

  typedef struct {
    logic [15:0] smp;
    logic        clip;
  } voice_out_t;

  typedef struct {
    voice_cfg_t  cfg;
    logic [15:0] smp;
    logic        restart;
    logic        typed;
    logic [15:0] exp_smp;
    logic        exp_clip;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // [15:0] in_sample
  logic        in_tuser;   // [0] restart
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;  // [15:0] sample
  logic        out_tuser;  // [0] clipped
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_wdata;

  sine_voice_am_fm_synth u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the voice registers and phase accumulators.
  voice_cfg_t             cur;
  logic [PHASE_BITS-1:0]  carrier_ph;
  logic [PHASE_BITS-1:0]  modulator_ph;
  int                     sine_cell [ROM_DEPTH];

  voice_out_t             expected_voice_q [$];
  dir_row_t               dir_rows [$];
  voice_out_t             mon_want;
  int                     mismatch_count = 0;
  int                     out_beats = 0;
  int                     cycle_count = 0;
  int                     items_sent = 0;
  logic                   steady = 1'b0;

  longint                 sine_poly [7] = '{61, -3864, 172272, -5026995, 85569306,
                                            -693598668, 1686629713};
  longint                 hx, hx2, hp, hr;

  // Quarter-wave table: odd Q30 polynomial evaluated at the center of each cell.
  initial begin
    for (int k = 0; k < ROM_DEPTH; k++) begin
      hx  = longint'(2 * k + 1) <<< (29 - TABLE_ADDR_BITS);
      hx2 = (hx * hx) >>> 30;
      hp  = sine_poly[0];
      for (int j = 1; j < 7; j++) hp = sine_poly[j] + ((hp * hx2) >>> 30);
      hr  = (((hp * hx) >>> 30) + 16384) >>> 15;
      if (hr < 0) hr = 0;
      if (hr > 32767) hr = 32767;
      sine_cell[k] = int'(hr);
    end
  end

  function automatic int sine_at(logic [PHASE_BITS-1:0] ph);
    logic [1:0]                 quad;
    logic [TABLE_ADDR_BITS-1:0] k;
    int                         v;
    quad = ph[PHASE_BITS-1 -: 2];
    k    = ph[PHASE_BITS-3 -: TABLE_ADDR_BITS];
    if (quad[0]) k = ~k;
    v = sine_cell[k];
    return quad[1] ? -v : v;
  endfunction

  task automatic predict_voice_sample(input logic [15:0] smp, input logic restart,
                                      output voice_out_t y);
    longint                amp_l;
    longint                sc;
    longint                sm;
    longint                r;
    longint                offs;
    logic [PHASE_BITS-1:0] step;
    if (restart) begin
      carrier_ph   = '0;
      modulator_ph = '0;
    end
    sc    = sine_at(carrier_ph);
    sm    = sine_at(modulator_ph);
    amp_l = longint'($signed(cur.amp));
    step  = cur.cstep;
    case (cur.mode)
      MODE_TONE: r = (amp_l * sc) >>> 15;
      MODE_MIX:  r = (longint'($signed(smp)) + ((amp_l * sc) >>> 15)) >>> 1;
      MODE_AM:   r = ((amp_l + ((longint'($signed(cur.depth)) * sm) >>> 15)) * sc) >>> 15;
      default: begin
        r    = (amp_l * sc) >>> 15;
        offs = (longint'($signed(cur.dev)) * sm) >>> 15;
        step = cur.cstep + offs[PHASE_BITS-1:0];
      end
    endcase
    y.clip = 1'b0;
    if (r > 32767) begin
      r      = 32767;
      y.clip = 1'b1;
    end
    if (r < -32768) begin
      r      = -32768;
      y.clip = 1'b1;
    end
    y.smp        = r[15:0];
    carrier_ph   = carrier_ph + step;
    modulator_ph = modulator_ph + cur.mstep;
  endtask

  task automatic flag_mismatch(input string what, input logic [15:0] got,
                               input logic [15:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS)
      $display("mismatch on output beat %0d: %s got %h want %h", out_beats, what, got, want);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_MODE:         cur.mode  = val[1:0];
      REG_AMPLITUDE:    cur.amp   = val[15:0];
      REG_CARRIER_STEP: cur.cstep = val;
      REG_MOD_STEP:     cur.mstep = val;
      REG_AM_DEPTH:     cur.depth = val[15:0];
      REG_FM_DEVIATION: cur.dev   = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Bits above the short registers carry random junk; the block must ignore it.
  task automatic program_voice(input voice_cfg_t c);
    logic [31:0] junk;
    junk = $urandom;
    write_reg(REG_MODE, {junk[31:2], c.mode});
    write_reg(REG_AMPLITUDE, {junk[15:0], c.amp});
    write_reg(REG_CARRIER_STEP, c.cstep);
    write_reg(REG_MOD_STEP, c.mstep);
    write_reg(REG_AM_DEPTH, {junk[31:16], c.depth});
    write_reg(REG_FM_DEVIATION, c.dev);
    write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, $urandom);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_voice_q.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic send_beat(input logic [15:0] smp, input logic restart, input logic typed,
                           input logic [15:0] exp_smp, input logic exp_clip);
    voice_out_t y;
    while (!steady && $urandom_range(0, 99) < 33) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= smp;
    in_tuser  <= restart;
    do @(posedge clk); while (!in_tready);
    predict_voice_sample(smp, restart, y);
    if (typed) begin
      y.smp  = exp_smp;
      y.clip = exp_clip;
    end
    expected_voice_q.push_back(y);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic add_row(input voice_cfg_t c, input logic [15:0] smp, input logic restart,
                         input logic typed, input logic [15:0] es, input logic ec);
    dir_row_t row;
    row.cfg      = c;
    row.smp      = smp;
    row.restart  = restart;
    row.typed    = typed;
    row.exp_smp  = es;
    row.exp_clip = ec;
    dir_rows.push_back(row);
  endtask

  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      2:       return 32'h8000_0000;
      3:       return 32'h7fff_ffff;
      4, 5:    return $urandom_range(0, 32'h00ff_ffff);
      default: return $urandom;
    endcase
  endfunction

  always @(negedge clk) begin
    out_tready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 33);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_voice_q.size() == 0) begin
        flag_mismatch("beat with nothing expected", out_tdata, 16'h0);
      end else begin
        mon_want = expected_voice_q.pop_front();
        if (out_tdata !== mon_want.smp) flag_mismatch("sample", out_tdata, mon_want.smp);
        if (out_tuser !== mon_want.clip)
          flag_mismatch("clipped", {15'h0, out_tuser}, {15'h0, mon_want.clip});
      end
      out_beats++;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    voice_cfg_t c;
    int         phase_no;
    int         n;
    logic [15:0] smp;

    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;
    cur          = '{MODE_TONE, AMPLITUDE_RST, 32'h0, 32'h0, 16'h0, 32'h0};
    carrier_ph   = '0;
    modulator_ph = '0;

    // Directed rows. The first one runs on the register values left by reset.
    add_row(cur, 16'h1234, 1'b0, 1'b0, 16'h0, 1'b0);
    add_row('{MODE_TONE, 16'h0000, 32'h0, 32'h0, 16'h0, 32'h0}, 16'h7fff, 1'b1,
            1'b1, 16'h0000, 1'b0);
    add_row('{MODE_MIX, 16'h0000, 32'h0, 32'h0, 16'h0, 32'h0}, 16'h7fff, 1'b0,
            1'b1, 16'h3fff, 1'b0);
    add_row('{MODE_MIX, 16'h0000, 32'h0, 32'h0, 16'h0, 32'h0}, 16'h8000, 1'b0,
            1'b1, 16'hc000, 1'b0);
    add_row('{MODE_MIX, 16'h0000, 32'h0, 32'h0, 16'h0, 32'h0}, 16'hffff, 1'b0,
            1'b1, 16'hffff, 1'b0);
    add_row('{MODE_TONE, 16'h7fff, 32'h4000_0000, 32'h0, 16'h0, 32'h0}, 16'h0, 1'b1,
            1'b0, 16'h0, 1'b0);
    add_row('{MODE_TONE, 16'h7fff, 32'h4000_0000, 32'h0, 16'h0, 32'h0}, 16'h0, 1'b0,
            1'b0, 16'h0, 1'b0);
    add_row('{MODE_TONE, 16'h8000, 32'h4000_0000, 32'h0, 16'h0, 32'h0}, 16'h0, 1'b0,
            1'b0, 16'h0, 1'b0);
    add_row('{MODE_TONE, 16'h7fff, 32'hffff_ffff, 32'h0, 16'h0, 32'h0}, 16'h0, 1'b1,
            1'b0, 16'h0, 1'b0);
    add_row('{MODE_TONE, 16'h7fff, 32'hffff_ffff, 32'h0, 16'h0, 32'h0}, 16'h0, 1'b0,
            1'b0, 16'h0, 1'b0);
    add_row('{MODE_MIX, 16'h7fff, 32'h0100_0000, 32'h0, 16'h0, 32'h0}, 16'h7fff, 1'b1,
            1'b0, 16'h0, 1'b0);
    add_row('{MODE_MIX, 16'h7fff, 32'h0100_0000, 32'h0, 16'h0, 32'h0}, 16'h8000, 1'b0,
            1'b0, 16'h0, 1'b0);
    // AM with both sines at their peak drives the product far past full scale.
    add_row('{MODE_AM, 16'h7fff, 32'h4000_0000, 32'h4000_0000, 16'h7fff, 32'h0}, 16'h0,
            1'b1, 1'b0, 16'h0, 1'b0);
    add_row('{MODE_AM, 16'h7fff, 32'h4000_0000, 32'h4000_0000, 16'h7fff, 32'h0}, 16'h0,
            1'b0, 1'b1, 16'h7fff, 1'b1);
    add_row('{MODE_AM, 16'h8000, 32'h4000_0000, 32'h4000_0000, 16'h8000, 32'h0}, 16'h0,
            1'b1, 1'b0, 16'h0, 1'b0);
    add_row('{MODE_AM, 16'h8000, 32'h4000_0000, 32'h4000_0000, 16'h8000, 32'h0}, 16'h0,
            1'b0, 1'b1, 16'h8000, 1'b1);
    add_row('{MODE_AM, 16'h0000, 32'h1234_5678, 32'h0, 16'h7fff, 32'h0}, 16'h0, 1'b1,
            1'b0, 16'h0, 1'b0);
    add_row('{MODE_AM, 16'h0000, 32'h1234_5678, 32'h0, 16'h7fff, 32'h0}, 16'h0, 1'b0,
            1'b0, 16'h0, 1'b0);
    add_row('{MODE_FM, 16'h7fff, 32'h0100_0000, 32'h0800_0000, 16'h0, 32'h7fff_ffff},
            16'h0, 1'b1, 1'b0, 16'h0, 1'b0);
    add_row('{MODE_FM, 16'h7fff, 32'h0100_0000, 32'h0800_0000, 16'h0, 32'h7fff_ffff},
            16'h0, 1'b0, 1'b0, 16'h0, 1'b0);
    add_row('{MODE_FM, 16'h7fff, 32'h0100_0000, 32'h0800_0000, 16'h0, 32'h7fff_ffff},
            16'h0, 1'b0, 1'b0, 16'h0, 1'b0);
    add_row('{MODE_FM, 16'h8000, 32'hffff_ffff, 32'hffff_ffff, 16'h0, 32'h8000_0000},
            16'h5a5a, 1'b1, 1'b0, 16'h0, 1'b0);
    add_row('{MODE_FM, 16'h8000, 32'hffff_ffff, 32'hffff_ffff, 16'h0, 32'h8000_0000},
            16'h0, 1'b0, 1'b0, 16'h0, 1'b0);
    add_row('{MODE_FM, 16'h8000, 32'hffff_ffff, 32'hffff_ffff, 16'h0, 32'h8000_0000},
            16'h0, 1'b0, 1'b0, 16'h0, 1'b0);
    add_row('{MODE_TONE, 16'h4000, 32'h0010_0000, 32'hffff_ffff, 16'h0, 32'h0}, 16'h0,
            1'b0, 1'b0, 16'h0, 1'b0);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].cfg != cur) begin
        wait_idle();
        program_voice(dir_rows[i].cfg);
      end
      send_beat(dir_rows[i].smp, dir_rows[i].restart, dir_rows[i].typed,
                dir_rows[i].exp_smp, dir_rows[i].exp_clip);
    end

    // Random part: one voice setting per phase, then a run of sample ticks.
    phase_no = 0;
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      wait_idle();
      c.mode  = 2'($urandom_range(0, 3));
      c.amp   = pick16();
      c.cstep = pick32();
      c.mstep = pick32();
      c.depth = pick16();
      c.dev   = pick32();
      program_voice(c);
      steady = (phase_no == 4);
      n = steady ? 200 : $urandom_range(20, 90);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(0, 9))
          0:       smp = 16'h7fff;
          1:       smp = 16'h8000;
          default: smp = 16'($urandom);
        endcase
        send_beat(smp, ($urandom_range(0, 19) == 0), 1'b0, 16'h0, 1'b0);
      end
      steady = 1'b0;
      phase_no++;
    end

    in_tvalid <= 1'b0;
    while (expected_voice_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

>>> files.f
rtl/svafm_pkg.sv
rtl/sine_voice_am_fm_synth.sv
verif/tb_sine_voice_am_fm_synth.sv
